// File: rtl/sil_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted insertion list: sizes, status and command codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package sil_pkg;

    localparam int CAPACITY    = 128;
    localparam int KEY_BITS    = 16;
    localparam int SUM_BITS    = 23;
    localparam int COUNT_BITS  = 8;
    localparam int POS_BITS    = 7;
    localparam int STATUS_BITS = 2;
    localparam int ADDR_BITS   = $clog2(CAPACITY);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD_POS = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming word
        logic decide;    // register the status of the command
        logic rd_pos;    // read the store at the requested position
        logic rd_scan;   // read the store just below the scan index
        logic shift_wr;  // move the entry read up into the scan slot
        logic key_wr;    // write the new key into the scan slot
        logic out_load;  // load the result register
    } sil_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic full;
        logic bad_pos;
        logic at_bottom;
        logic greater;
        logic out_free;
    } sil_stat_t;

endpackage

// File: rtl/sil_in_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one command word.
// Depends on sil_pkg.
interface sil_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [sil_pkg::KEY_BITS-1:0]  key_value;
    logic        [sil_pkg::POS_BITS-1:0]  position;

    modport source (output valid, command, key_value, position, input ready);
    modport sink   (input valid, command, key_value, position, output ready);
endinterface

// File: rtl/sil_out_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result word.
// Depends on sil_pkg.
interface sil_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sil_pkg::KEY_BITS-1:0]    read_value;
    logic        [sil_pkg::COUNT_BITS-1:0]  entry_count;
    logic signed [sil_pkg::SUM_BITS-1:0]    key_sum;
    logic        [sil_pkg::STATUS_BITS-1:0] status;

    modport source (output valid, read_value, entry_count, key_sum, status, input ready);
    modport sink   (input valid, read_value, entry_count, key_sum, status, output ready);
endinterface

// File: rtl/sil_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the sorted insertion list.
// Depends on sil_pkg.
module sil_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sil_pkg::sil_stat_t stat,
    output sil_pkg::sil_ctrl_t ctl
);
    import sil_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_RWAIT  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.decide = 1'b1;
                if (stat.is_read)
                begin
                    if (stat.bad_pos)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        ctl.rd_pos = 1'b1;
                        state_next = S_RWAIT;
                    end
                end
                else if (stat.full)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_RWAIT:
            begin
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (stat.at_bottom)
                begin
                    ctl.key_wr = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    ctl.rd_scan = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.greater)
                begin
                    ctl.shift_wr = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    ctl.key_wr = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sil_dp.sv
`timescale 1ns / 1ps
// Datapath of the sorted insertion list: key store memory, count, sum,
// scan index and result register. Depends on sil_pkg.
module sil_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sil_pkg::sil_ctrl_t                    ctl,
    output sil_pkg::sil_stat_t                    stat,
    input  logic                                  in_command,
    input  logic signed [sil_pkg::KEY_BITS-1:0]   in_key_value,
    input  logic        [sil_pkg::POS_BITS-1:0]   in_position,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [sil_pkg::KEY_BITS-1:0]   out_read_value,
    output logic        [sil_pkg::COUNT_BITS-1:0] out_entry_count,
    output logic signed [sil_pkg::SUM_BITS-1:0]   out_key_sum,
    output logic        [sil_pkg::STATUS_BITS-1:0] out_status
);
    import sil_pkg::*;

    logic signed [KEY_BITS-1:0] store_mem [CAPACITY];

    logic                         cmd_reg;
    logic signed [KEY_BITS-1:0]   key_reg;
    logic        [POS_BITS-1:0]   pos_reg;
    logic        [COUNT_BITS-1:0] idx_reg;
    logic        [COUNT_BITS-1:0] count_reg;
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic        [STATUS_BITS-1:0] status_reg;
    logic signed [KEY_BITS-1:0]   rd_data_reg;
    logic                         out_valid_reg;
    logic signed [KEY_BITS-1:0]   out_value_reg;
    logic        [COUNT_BITS-1:0] out_count_reg;
    logic signed [SUM_BITS-1:0]   out_sum_reg;
    logic        [STATUS_BITS-1:0] out_status_reg;

    logic                         wr_en;
    logic        [ADDR_BITS-1:0]  wr_addr;
    logic signed [KEY_BITS-1:0]   wr_data;
    logic                         rd_en;
    logic        [ADDR_BITS-1:0]  rd_addr;
    logic        [COUNT_BITS-1:0] idx_dec;
    logic                         full;
    logic                         bad_pos;

    assign idx_dec = idx_reg - 1'b1;
    assign full    = (count_reg == COUNT_BITS'(CAPACITY));
    assign bad_pos = (COUNT_BITS'(pos_reg) >= count_reg);

    assign wr_en   = ctl.shift_wr | ctl.key_wr;
    assign wr_addr = idx_reg[ADDR_BITS-1:0];
    assign wr_data = ctl.shift_wr ? rd_data_reg : key_reg;
    assign rd_en   = ctl.rd_pos | ctl.rd_scan;
    assign rd_addr = ctl.rd_pos ? pos_reg[ADDR_BITS-1:0] : idx_dec[ADDR_BITS-1:0];

    assign stat.is_read   = (cmd_reg == CMD_READ);
    assign stat.full      = full;
    assign stat.bad_pos   = bad_pos;
    assign stat.at_bottom = (idx_reg == '0);
    assign stat.greater   = (rd_data_reg > key_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_command;
            key_reg <= in_key_value;
            pos_reg <= in_position;
            idx_reg <= count_reg;
        end
        else if (ctl.shift_wr)
        begin
            idx_reg <= idx_dec;
        end
        if (ctl.decide)
        begin
            if (cmd_reg == CMD_READ)
            begin
                status_reg <= bad_pos ? ST_BAD_POS : ST_OK;
            end
            else
            begin
                status_reg <= full ? ST_FULL : ST_OK;
            end
        end
        if (ctl.out_load)
        begin
            out_value_reg  <= (cmd_reg == CMD_READ && status_reg == ST_OK) ? rd_data_reg : '0;
            out_count_reg  <= count_reg;
            out_sum_reg    <= sum_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.key_wr)
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_BITS'(key_reg);
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_read_value  = out_value_reg;
    assign out_entry_count = out_count_reg;
    assign out_key_sum     = out_sum_reg;
    assign out_status      = out_status_reg;

endmodule

// File: rtl/sorted_insert_list_with_sum.sv
`timescale 1ns / 1ps
// Top level of the sorted insertion list with running sum.
// Depends on sil_pkg, sil_in_if, sil_out_if, sil_ctrl and sil_dp.
//
// Usage: the request channel takes one word per command: an insert of
// key_value, or a read of the entry at sorted position. Every command gives
// exactly one word on the result channel, with the key read (zero unless a
// good read), the entry count and the key sum after the command, and a status.
// Commands are handled one at a time. A good read passes through the decide,
// read-wait and result states after acceptance; a dropped insert or a bad
// read goes from the decide state straight to the result state. An insert
// walks the store from the top entry downward, reading each entry and moving
// it up through the one read port and one write port of the key memory while
// it is larger than the new key, then writes the new key into the freed slot.
// The request channel is ready again the cycle after the result is loaded
// into the output register.
// Reset clears the entry count, the sum and the result valid flag; the key
// memory is not cleared, since only filled positions are ever read.
// When the receiver stalls, the result word holds in the output register and
// one more command may be accepted; that command then waits to deliver its
// result until the held word is taken.
module sorted_insert_list_with_sum (
    input  logic      clk,
    input  logic      rst_n,
    sil_in_if.sink    request,
    sil_out_if.source result
);
    import sil_pkg::*;

    sil_ctrl_t ctl;
    sil_stat_t stat;

    // The controller owns the request handshake and sequences the datapath.
    sil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // The datapath holds the store, the count and sum, and the result register.
    sil_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .in_command      (request.command),
        .in_key_value    (request.key_value),
        .in_position     (request.position),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_read_value  (result.read_value),
        .out_entry_count (result.entry_count),
        .out_key_sum     (result.key_sum),
        .out_status      (result.status)
    );

endmodule

// File: bench/sorted_insert_list_with_sum_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_insert_list_with_sum: random traffic on both channels.
// Depends on sil_pkg, sil_in_if, sil_out_if and the block itself.
module sorted_insert_list_with_sum_tb;

    import sil_pkg::*;

    // The bench gives up after this many clock cycles. The slowest correct run
    // (every insert shifting the whole store, every word meeting the longest
    // gaps on both sides) stays well below it.
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int DRAIN_CYCLES  = 2 * CAPACITY + 40;
    localparam int RANDOM_WORDS  = 930;
    localparam int PHASE_LENGTH  = 100;

    // One result word as the block should deliver it.
    typedef struct packed {
        logic signed [KEY_BITS-1:0]  read_value;
        logic [COUNT_BITS-1:0]       entry_count;
        logic signed [SUM_BITS-1:0]  key_sum;
        logic [STATUS_BITS-1:0]      status;
    } result_word_t;

    // Tracks the sorted store, the count and the sum, and holds the result words
    // still owed by the block in the order the commands were accepted.
    class key_list_tracker;
        logic signed [KEY_BITS-1:0] sorted_keys [CAPACITY];
        int unsigned                filled;
        logic signed [SUM_BITS-1:0] key_total;
        result_word_t               owed_words [$];
        int unsigned                mismatch_count;

        function new();
            filled         = 0;
            key_total      = '0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        function void note_command(logic cmd, logic signed [KEY_BITS-1:0] key,
                                   logic [POS_BITS-1:0] pos);
            result_word_t w;
            int unsigned  slot;
            int unsigned  i;
            w.read_value = '0;
            w.status     = ST_OK;
            if (cmd == CMD_INSERT)
            begin
                if (filled >= CAPACITY)
                begin
                    w.status = ST_FULL;
                end
                else
                begin
                    // Equal keys already stored stay below the new one.
                    slot = 0;
                    while (slot < filled && sorted_keys[slot] <= key)
                        slot++;
                    for (i = filled; i > slot; i--)
                        sorted_keys[i] = sorted_keys[i-1];
                    sorted_keys[slot] = key;
                    filled++;
                    key_total = key_total + key;
                end
            end
            else
            begin
                if (pos < filled)
                    w.read_value = sorted_keys[pos];
                else
                    w.status = ST_BAD_POS;
            end
            w.entry_count = COUNT_BITS'(filled);
            w.key_sum     = key_total;
            owed_words.push_back(w);
        endfunction

        function void check_word(result_word_t got);
            result_word_t want;
            if (owed_words.size() == 0)
            begin
                $display("%0t: result word with none expected: value %0d count %0d sum %0d status %0d",
                         $time, got.read_value, got.entry_count, got.key_sum, got.status);
                mismatch_count++;
                return;
            end
            want = owed_words.pop_front();
            if (got.read_value !== want.read_value)
            begin
                $display("%0t: read_value expected %0d, actual %0d",
                         $time, want.read_value, got.read_value);
                mismatch_count++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $display("%0t: entry_count expected %0d, actual %0d",
                         $time, want.entry_count, got.entry_count);
                mismatch_count++;
            end
            if (got.key_sum !== want.key_sum)
            begin
                $display("%0t: key_sum expected %0d, actual %0d",
                         $time, want.key_sum, got.key_sum);
                mismatch_count++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatch_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sil_in_if  request_ch ();
    sil_out_if result_ch ();

    sorted_insert_list_with_sum dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch.sink),
        .result  (result_ch.source)
    );

    key_list_tracker tracker = new();

    // Percent chance of a gap after each word on the request side, and of a
    // stall after each ready cycle on the result side. The main sequence
    // changes them from phase to phase, including phases with no idling.
    int unsigned send_gap_pct  = 0;
    int unsigned take_stall_pct = 0;
    int unsigned cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Most gaps are short; about one in ten is a long one, so that
    // the block also sees both channels quiet for a while.
    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    // Keys lean toward the extremes and toward a narrow band around zero, the
    // latter to get many equal keys in the store.
    function automatic logic signed [KEY_BITS-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(7);
        unique case (sel)
            0:       return ($urandom_range(1) == 0) ? 16'sh7fff : 16'sh8000;
            1, 2:    return KEY_BITS'($signed($urandom_range(16)) - 8);
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    // Read positions mostly land inside the filled part of the store; the rest
    // are anywhere in the 7-bit range.
    function automatic logic [POS_BITS-1:0] pick_position();
        if (tracker.filled > 0 && $urandom_range(99) < 85)
            return POS_BITS'($urandom_range(tracker.filled - 1));
        return POS_BITS'($urandom);
    endfunction

    // Presents one word on the request channel at the falling edge and holds it
    // until the block takes it. Valid stays high into the next word when no gap
    // follows, so back-to-back words are offered without a bubble.
    task automatic send_word(input logic cmd, input logic signed [KEY_BITS-1:0] key,
                             input logic [POS_BITS-1:0] pos);
        int unsigned gap;
        request_ch.valid     = 1'b1;
        request_ch.command   = cmd;
        request_ch.key_value = key;
        request_ch.position  = pos;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        @(negedge clk);
        gap = pick_gap(send_gap_pct);
        if (gap > 0)
        begin
            request_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic insert_key(input logic signed [KEY_BITS-1:0] key);
        send_word(CMD_INSERT, key, POS_BITS'($urandom));
    endtask

    task automatic read_position(input logic [POS_BITS-1:0] pos);
        send_word(CMD_READ, pick_key(), pos);
    endtask

    // Result side: ready toggles at the falling edge with random stalls.
    initial
    begin
        int unsigned hold;
        hold = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                result_ch.ready = 1'b0;
                hold--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                hold = pick_gap(take_stall_pct);
            end
        end
    end

    // Both channels are sampled at the rising edge: every accepted command word
    // updates the tracker, and every accepted result word is checked against the
    // oldest word still owed.
    always @(posedge clk)
    begin
        result_word_t got;
        if (rst_n)
        begin
            if (request_ch.valid && request_ch.ready)
                tracker.note_command(request_ch.command, request_ch.key_value,
                                     request_ch.position);
            if (result_ch.valid && result_ch.ready)
            begin
                got.read_value  = result_ch.read_value;
                got.entry_count = result_ch.entry_count;
                got.key_sum     = result_ch.key_sum;
                got.status      = result_ch.status;
                tracker.check_word(got);
            end
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned phase;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        request_ch.valid     = 1'b0;
        request_ch.command   = CMD_INSERT;
        request_ch.key_value = '0;
        request_ch.position  = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, back to back with a ready receiver. Reads of an empty
        // store must flag a bad position, both at the bottom and the top of the
        // range.
        read_position(7'd0);
        read_position(7'd127);
        insert_key(16'sh7fff);
        insert_key(16'sh8000);
        insert_key(16'sh0000);
        // Equal keys: the second zero and the second maximum go above their twins.
        insert_key(16'sh0000);
        insert_key(-16'sd1);
        insert_key(16'sd1);
        insert_key(16'sh7fff);
        for (n = 0; n < 7; n++)
            read_position(POS_BITS'(n));
        // Position equal to the count is the first one not filled.
        read_position(7'd7);
        read_position(7'd127);
        // A read ignores the key and an insert ignores the position, so drive
        // the unused field with its extremes once.
        send_word(CMD_READ, 16'sh8000, 7'd3);
        send_word(CMD_INSERT, -16'sd2, 7'd127);
        read_position(7'd0);

        // Random part. While the store has room, inserts and reads are mixed so
        // that every fill level is read back; once it is full, the traffic turns
        // to reads over the whole store and inserts that must be dropped.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % PHASE_LENGTH == 0)
            begin
                phase = (n / PHASE_LENGTH) % 4;
                unique case (phase)
                    0:
                    begin
                        send_gap_pct   = 0;
                        take_stall_pct = 0;
                    end
                    1:
                    begin
                        send_gap_pct   = 30;
                        take_stall_pct = 30;
                    end
                    2:
                    begin
                        send_gap_pct   = 0;
                        take_stall_pct = 60;
                    end
                    default:
                    begin
                        send_gap_pct   = 60;
                        take_stall_pct = 10;
                    end
                endcase
            end
            // Once in the middle, let the block drain completely before going on.
            if (n == RANDOM_WORDS / 2)
            begin
                request_ch.valid = 1'b0;
                while (tracker.pending() != 0)
                    @(negedge clk);
            end
            if (tracker.filled < CAPACITY)
            begin
                if ($urandom_range(99) < 40)
                    insert_key(pick_key());
                else
                    read_position(pick_position());
            end
            else
            begin
                if ($urandom_range(99) < 20)
                    insert_key(pick_key());
                else
                    read_position(POS_BITS'($urandom));
            end
        end
        request_ch.valid = 1'b0;

        // Wait for the last words, then long enough for any stray word to show.
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (tracker.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
